[hdl/assert_macros.svh]
// Assertion helpers shared by the allocator modules.
// Every check is sampled on the rising clock edge and is ignored during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/csa_pkg.sv]
package csa_pkg;

   // Default window size, in 4 KB slots
   localparam int SLOTS_DEFAULT = 256;

   localparam int PAGE_WIDTH  = 20;
   localparam int FIRST_WIDTH = 8;
   localparam int COUNT_WIDTH = 9;
   localparam int SLOT_WIDTH  = 8;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ROOM   = 2'd1;
   localparam logic [1:0] ST_BAD_RANGE = 2'd2;

   typedef struct packed {
      logic                   command;
      logic [FIRST_WIDTH-1:0] first_slot;
      logic [COUNT_WIDTH-1:0] page_count;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_WIDTH-1:0] granted_slot;
      logic [PAGE_WIDTH-1:0] granted_page;
   } rsp_item_type;

   // Source of a flag fill sweep
   typedef enum logic [1:0] {
      FILL_CLEAR,
      FILL_MARK,
      FILL_FREE
   } fill_mode_type;

   // Kind of result to load into the output register
   typedef enum logic [1:0] {
      RES_OK_ALLOC,
      RES_OK_FREE,
      RES_NO_ROOM,
      RES_BAD_RANGE
   } res_kind_type;

   typedef struct packed {
      logic          take_req;
      logic          scan_start;
      logic          scan_step;
      logic          fill_load;
      fill_mode_type fill_mode;
      logic          fill_step;
      logic          res_load;
      res_kind_type  res_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic alloc_bad;
      logic free_bad;
      logic free_zero;
      logic scan_hit;
      logic scan_miss;
      logic fill_last;
      logic rsp_room;
   } dp_status_type;

endpackage

[hdl/csa_datapath.sv]
module csa_datapath
   import csa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_item_type          req_item,
   input  logic                  csr_wr_en,
   input  logic [PAGE_WIDTH-1:0] csr_wr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  dp_cmd_type            cmd,
   output dp_status_type         status
);

   `include "assert_macros.svh"

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = ((CW > COUNT_WIDTH) ? CW : COUNT_WIDTH) + 1;

   // Flag store and its registered read port
   logic slot_used_mem [SLOTS];
   logic rd_data_ff;

   logic [PAGE_WIDTH-1:0] base_page_ff;

   // Latched item
   logic          command_ff;
   logic [EW-1:0] first_ff;
   logic [EW-1:0] count_ff;

   // Scan state
   logic [CW-1:0] scan_addr_ff;
   logic          chk_valid_ff;
   logic [SW-1:0] chk_idx_ff;
   logic [CW-1:0] run_ff;
   logic [SW-1:0] start_ff;

   // Fill sweep state
   logic [SW-1:0] wr_ptr_ff;
   logic [CW-1:0] wr_left_ff;
   logic          wr_val_ff;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   logic          scan_issue;
   logic [CW-1:0] count_run;
   logic [CW-1:0] run_in;
   logic          hit;
   logic [CW:0]   start_wide;
   logic [EW-1:0] free_end;

   assign count_run  = count_ff[CW-1:0];
   assign scan_issue = cmd.scan_step && (scan_addr_ff < CW'(SLOTS));
   assign run_in     = rd_data_ff ? '0 : run_ff + CW'(1);
   assign hit        = chk_valid_ff && (run_in == count_run);
   assign start_wide = (CW+1)'(chk_idx_ff) + (CW+1)'(1) - (CW+1)'(count_run);
   assign free_end   = first_ff + count_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff <= '0;
      end else if (csr_wr_en) begin
         base_page_ff <= csr_wr_data;
      end
   end

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         command_ff <= req_item.command;
         first_ff   <= EW'(req_item.first_slot);
         count_ff   <= EW'(req_item.page_count);
      end
   end

   // Flag store: one write and one read a cycle
   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         slot_used_mem[wr_ptr_ff] <= wr_val_ff;
      end
      if (scan_issue) begin
         rd_data_ff <= slot_used_mem[scan_addr_ff[SW-1:0]];
      end
   end

   // Walk the flags: issue a read each cycle, check the one read last cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         chk_valid_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
         run_ff       <= '0;
      end else if (cmd.scan_step) begin
         if (scan_issue) begin
            scan_addr_ff <= scan_addr_ff + CW'(1);
            chk_idx_ff   <= scan_addr_ff[SW-1:0];
         end
         if (chk_valid_ff) begin
            run_ff <= run_in;
         end
         if (hit) begin
            start_ff <= start_wide[SW-1:0];
         end
      end
   end

   // Fill sweep: clear after reset, mark on allocate, clear on free
   always_ff @(posedge clock) begin
      if (cmd.fill_load) begin
         case (cmd.fill_mode)
            FILL_CLEAR: begin
               wr_ptr_ff  <= '0;
               wr_left_ff <= CW'(SLOTS);
               wr_val_ff  <= 1'b0;
            end
            FILL_MARK: begin
               wr_ptr_ff  <= start_ff;
               wr_left_ff <= count_run;
               wr_val_ff  <= 1'b1;
            end
            default: begin
               wr_ptr_ff  <= first_ff[SW-1:0];
               wr_left_ff <= count_run;
               wr_val_ff  <= 1'b0;
            end
         endcase
      end else if (cmd.fill_step) begin
         wr_ptr_ff  <= wr_ptr_ff + SW'(1);
         wr_left_ff <= wr_left_ff - CW'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         case (cmd.res_kind)
            RES_OK_ALLOC: begin
               rsp_item_ff.status       <= ST_OK;
               rsp_item_ff.granted_slot <= SLOT_WIDTH'(start_ff);
               rsp_item_ff.granted_page <= base_page_ff + PAGE_WIDTH'(start_ff);
            end
            RES_OK_FREE: begin
               rsp_item_ff.status       <= ST_OK;
               rsp_item_ff.granted_slot <= '0;
               rsp_item_ff.granted_page <= '0;
            end
            RES_NO_ROOM: begin
               rsp_item_ff.status       <= ST_NO_ROOM;
               rsp_item_ff.granted_slot <= '0;
               rsp_item_ff.granted_page <= '0;
            end
            default: begin
               rsp_item_ff.status       <= ST_BAD_RANGE;
               rsp_item_ff.granted_slot <= '0;
               rsp_item_ff.granted_page <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Status towards the controller
   assign status.is_free   = (command_ff == CMD_FREE);
   assign status.alloc_bad = (count_ff == '0) || (count_ff > EW'(SLOTS));
   assign status.free_bad  = (first_ff >= EW'(SLOTS)) || (free_end > EW'(SLOTS));
   assign status.free_zero = (count_ff == '0);
   assign status.scan_hit  = cmd.scan_step && hit;
   assign status.scan_miss = cmd.scan_step && chk_valid_ff && !hit
                             && (chk_idx_ff == SW'(SLOTS - 1));
   assign status.fill_last = (wr_left_ff == CW'(1));
   assign status.rsp_room  = !rsp_valid_ff || rsp_ready;

   `ASSERT_IMPLIES(a_fill_in_range, cmd.fill_step, wr_left_ff != '0)
   `ASSERT_IMPLIES(a_run_below_count, cmd.scan_step && chk_valid_ff, run_ff < count_run)
   `ASSERT_IMPLIES(a_load_needs_room, cmd.res_load, !rsp_valid_ff || rsp_ready)
   `ASSERT_NEXT(a_load_shows_valid, cmd.res_load, rsp_valid_ff)

endmodule

[hdl/csa_controller.sv]
module csa_controller
   import csa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_INIT,
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_MARK_LD,
      S_MARK,
      S_FREE,
      S_REPLY
   } state_type;

   state_type    state_ff, state_in;
   res_kind_type kind_ff, kind_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.fill_load = 1'b1;
            cmd.fill_mode = FILL_CLEAR;
            state_in      = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.is_free) begin
               if (status.alloc_bad) begin
                  kind_in  = RES_NO_ROOM;
                  state_in = S_REPLY;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else if (status.free_bad) begin
               kind_in  = RES_BAD_RANGE;
               state_in = S_REPLY;
            end else if (status.free_zero) begin
               kind_in  = RES_OK_FREE;
               state_in = S_REPLY;
            end else begin
               cmd.fill_load = 1'b1;
               cmd.fill_mode = FILL_FREE;
               state_in      = S_FREE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = S_MARK_LD;
            end else if (status.scan_miss) begin
               kind_in  = RES_NO_ROOM;
               state_in = S_REPLY;
            end
         end
         S_MARK_LD: begin
            cmd.fill_load = 1'b1;
            cmd.fill_mode = FILL_MARK;
            state_in      = S_MARK;
         end
         S_MARK: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               kind_in  = RES_OK_ALLOC;
               state_in = S_REPLY;
            end
         end
         S_FREE: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               kind_in  = RES_OK_FREE;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            cmd.res_kind = kind_ff;
            if (status.rsp_room) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Hold state and the pending result kind
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         kind_ff  <= RES_OK_FREE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `ASSERT_NEXT(a_accept_goes_check, req_valid && req_ready, state_ff == S_CHECK)
   `ASSERT_IMPLIES(a_one_fill_source, cmd.fill_load, !cmd.fill_step && !cmd.scan_step)

endmodule

[hdl/contiguous_slot_allocator_unit.sv]
// First-fit allocator of contiguous 4 KB page slots in one address window.
// Input channel req_valid/req_ready/req_item: allocate page_count slots, or
// free page_count slots from first_slot. Result channel rsp_valid/rsp_ready/
// rsp_item: exactly one item per request, in request order, carrying status,
// the granted slot and its page number (base_page plus slot).
// csr_wr_en/csr_wr_data write base_page; write it only while the block idles.
// After reset the flag store is swept clear, one slot a cycle; req_ready
// stays low until the sweep ends.
// Flow: a request is taken at an edge with req_ready high; its result is
// loaded into the output register, and the next request can be taken in the
// cycle after that, so requests are handled one at a time. A rejected request
// or a zero-length free goes straight to the result; a free clears its range
// one slot a cycle on the write port. An allocate walks the flags through the
// single read port of the store, one slot a cycle, then marks one slot a cycle
// on the write port; a miss walks every slot. The result waits in an output
// register; a new request is taken while it waits, and its result is loaded
// once the receiver has taken the previous one, so a stalled receiver holds
// back one request.
module contiguous_slot_allocator_unit
   import csa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [PAGE_WIDTH-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence the request
   csa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Hold the flags, walk and fill them, form the result
   csa_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

[test/slot_allocator_checker.sv]
module slot_allocator_checker
   import csa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [PAGE_WIDTH-1:0] csr_wr_data,
   output int unsigned           mismatch_count,
   output int unsigned           pending_count
);

   localparam int MAX_REPORTS = 40;

   // Shadow of the used flags and of the window base
   logic [SLOT_COUNT-1:0] slot_busy;
   logic [PAGE_WIDTH-1:0] window_base;
   rsp_item_type          grant_queue[$];
   int unsigned           mismatches = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Print one line (up to a cap) and count the mismatch
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Expected result for one request item (first-fit grant for an allocate); updates the shadow flags
   function automatic rsp_item_type predict_grant(input req_item_type item);
      rsp_item_type res;
      int           run;
      int           start;
      int           s;
      int           count;
      res   = '0;
      run   = 0;
      start = -1;
      count = int'(item.page_count);
      if (item.command == CMD_ALLOC) begin
         res.status = ST_NO_ROOM;
         if (count != 0 && count <= SLOT_COUNT) begin
            // walk the flags, stop at the first run long enough
            for (s = 0; s < SLOT_COUNT && start < 0; s++) begin
               run = slot_busy[s] ? 0 : run + 1;
               if (run == count) begin
                  start = s + 1 - count;
               end
            end
            if (start >= 0) begin
               for (s = start; s < start + count; s++) begin
                  slot_busy[s] = 1'b1;
               end
               res.status       = ST_OK;
               res.granted_slot = start[SLOT_WIDTH-1:0];
               res.granted_page = window_base + start[PAGE_WIDTH-1:0];
            end
         end
      end else if (int'(item.first_slot) >= SLOT_COUNT ||
                   int'(item.first_slot) + count > SLOT_COUNT) begin
         res.status = ST_BAD_RANGE;
      end else begin
         // clear the range whatever its flags held
         for (s = int'(item.first_slot); s < int'(item.first_slot) + count; s++) begin
            slot_busy[s] = 1'b0;
         end
         res.status = ST_OK;
      end
      return res;
   endfunction

   // Watch both channels and the register port on every edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         slot_busy   = '0;
         window_base = '0;
         grant_queue.delete();
      end else begin
         // compare a taken result with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (grant_queue.size() == 0) begin
               report_mismatch("unexpected result item, status",
                               32'(rsp_item.status), 32'(0));
            end else begin
               want = grant_queue.pop_front();
               if (rsp_item.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
               end
               if (rsp_item.granted_slot !== want.granted_slot) begin
                  report_mismatch("granted_slot", 32'(rsp_item.granted_slot),
                                  32'(want.granted_slot));
               end
               if (rsp_item.granted_page !== want.granted_page) begin
                  report_mismatch("granted_page", 32'(rsp_item.granted_page),
                                  32'(want.granted_page));
               end
            end
         end
         if (csr_wr_en) begin
            window_base = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            grant_queue.push_back(predict_grant(req_item));
         end
      end
      pending_count  <= grant_queue.size();
      mismatch_count <= mismatches;
   end

endmodule

[test/contiguous_slot_allocator_unit_tb.sv]
module contiguous_slot_allocator_unit_tb;
   import csa_pkg::*;

   localparam int PHASE_ITEMS  = 366;
   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int DRAIN_CYCLES = 2 * SLOTS_DEFAULT + 10;
   localparam int LONG_HOLD    = 4000;
   localparam int HOLD_AFTER   = 150;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_item_type          req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en   = 1'b0;
   logic [PAGE_WIDTH-1:0] csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int          calm_left = 0;
   int          cycle_count = 0;

   logic [PAGE_WIDTH-1:0] phase_base [5];

   always #5 clock = ~clock;

   contiguous_slot_allocator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slot_allocator_checker #(.SLOT_COUNT(SLOTS_DEFAULT)) grant_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 88) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(24, 4);
      return $urandom_range(400, 40);
   endfunction

   // Sender gap, with the odd stretch of back-to-back items
   function automatic int sender_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(99) < 4) begin
         calm_left = $urandom_range(60, 20);
      end
      return idle_length();
   endfunction

   function automatic req_item_type make_request(input logic cmd,
                                                 input int first, input int count);
      req_item_type item;
      item.command    = cmd;
      item.first_slot = first[FIRST_WIDTH-1:0];
      item.page_count = count[COUNT_WIDTH-1:0];
      return item;
   endfunction

   // Mostly small runs; some large, oversized and empty ones, frees all over
   function automatic req_item_type random_request();
      req_item_type item;
      int           pick;
      int           first;
      int           count;
      int           room;
      first = $urandom_range(255);
      pick  = $urandom_range(99);
      if (pick < 55) begin
         pick = $urandom_range(99);
         if (pick < 80)      count = $urandom_range(8, 1);
         else if (pick < 92) count = $urandom_range(64, 9);
         else if (pick < 97) count = $urandom_range(256, 65);
         else if (pick < 98) count = 0;
         else                count = $urandom_range(511, 257);
         item = make_request(CMD_ALLOC, first, count);
      end else begin
         pick = $urandom_range(99);
         room = SLOTS_DEFAULT - first;
         if (pick < 3) begin
            first = 0;
            count = SLOTS_DEFAULT;
         end else if (pick < 12) begin
            count = $urandom_range(511, room + 1);
         end else if (pick < 15) begin
            count = 0;
         end else begin
            count = $urandom_range(room < 16 ? room : 16, 1);
         end
         item = make_request(CMD_FREE, first, count);
      end
      return item;
   endfunction

   // Offer one item, hold it until taken, then maybe idle
   task automatic offer_request(input req_item_type item);
      int gap;
      req_item  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_window_base(input logic [PAGE_WIDTH-1:0] base);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Result side: ready stretches, short stalls, one long hold-off
   initial begin : result_taker
      int high_len;
      int low_len;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         high_len = ($urandom_range(99) < 85) ? $urandom_range(8, 1)
                                              : $urandom_range(500, 50);
         repeat (high_len) begin
            @(posedge clock);
            if (rsp_valid && rsp_ready) taken++;
         end
         if (!held && taken >= HOLD_AFTER) begin
            held    = 1'b1;
            low_len = LONG_HOLD;
         end else begin
            low_len = idle_length();
         end
         if (low_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (low_len) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("contiguous_slot_allocator_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      phase_base[0] = 20'hFFFFF;
      phase_base[1] = 20'h00000;
      phase_base[2] = 20'h55555;
      phase_base[3] = PAGE_WIDTH'($urandom_range(20'hFFFFF));
      phase_base[4] = 20'hAAAAA;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // let the clearing sweep finish before the first register write
      do @(posedge clock); while (!req_ready);

      // Directed part; the base makes higher slots wrap past the page range
      set_window_base(20'hFFFF0);
      offer_request(make_request(CMD_ALLOC, 0, 0));
      offer_request(make_request(CMD_ALLOC, 255, 257));
      offer_request(make_request(CMD_ALLOC, 170, 511));
      offer_request(make_request(CMD_ALLOC, 0, 1));
      offer_request(make_request(CMD_ALLOC, 85, 3));
      offer_request(make_request(CMD_FREE, 1, 1));
      offer_request(make_request(CMD_ALLOC, 0, 2));
      offer_request(make_request(CMD_ALLOC, 0, 1));
      offer_request(make_request(CMD_FREE, 0, 0));
      offer_request(make_request(CMD_FREE, 9, 0));
      offer_request(make_request(CMD_ALLOC, 0, 20));
      offer_request(make_request(CMD_ALLOC, 0, 12));
      offer_request(make_request(CMD_FREE, 200, 57));
      offer_request(make_request(CMD_FREE, 255, 2));
      offer_request(make_request(CMD_FREE, 0, 511));
      offer_request(make_request(CMD_FREE, 255, 1));
      offer_request(make_request(CMD_FREE, 0, 256));
      offer_request(make_request(CMD_ALLOC, 0, 256));
      offer_request(make_request(CMD_ALLOC, 0, 1));
      offer_request(make_request(CMD_FREE, 10, 5));
      offer_request(make_request(CMD_FREE, 10, 5));
      offer_request(make_request(CMD_ALLOC, 0, 6));
      offer_request(make_request(CMD_ALLOC, 0, 5));
      offer_request(make_request(CMD_FREE, 0, 256));

      // Random part, one window base per phase
      foreach (phase_base[p]) begin
         set_window_base(phase_base[p]);
         repeat (PHASE_ITEMS) offer_request(random_request());
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("contiguous_slot_allocator_unit regression: pass");
      end else begin
         $display("contiguous_slot_allocator_unit regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/csa_pkg.sv
hdl/csa_datapath.sv
hdl/csa_controller.sv
hdl/contiguous_slot_allocator_unit.sv
test/slot_allocator_checker.sv
test/contiguous_slot_allocator_unit_tb.sv
